// File: src/dvrm_pkg.sv
package dvrm_pkg;

    localparam int ADDR_W   = 32;
    localparam int COST_W   = 8;
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 7;
    localparam int USED_W   = 8;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BETTER  = 3'd0,
        ACT_REFRESH = 3'd1,
        ACT_INSERT  = 3'd2,
        ACT_IGNORE  = 3'd3,
        ACT_FULL    = 3'd4
    } action_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [COST_W-1:0] cost;
    } route_entry_t;

endpackage

// File: src/dvrm_req_if.sv
interface dvrm_req_if import dvrm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] next_hop_addr;
    logic [COST_W-1:0] route_cost;

    modport source (output valid, dest_addr, next_hop_addr, route_cost, input ready);
    modport sink   (input valid, dest_addr, next_hop_addr, route_cost, output ready);
endinterface

// File: src/dvrm_rsp_if.sv
interface dvrm_rsp_if import dvrm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] merge_action;
    logic [INDEX_W-1:0]  entry_index;
    logic [COST_W-1:0]   stored_cost;
    logic [USED_W-1:0]   entries_used;

    modport source (output valid, merge_action, entry_index, stored_cost, entries_used,
                    input ready);
    modport sink   (input valid, merge_action, entry_index, stored_cost, entries_used,
                    output ready);
endinterface

// File: src/distance_vector_route_merge_core.sv
// Distance-vector route merge.
// req channel: one advertised route (dest_addr, next_hop_addr, route_cost).
// rsp channel: one item per route (merge_action, entry_index, stored_cost,
// entries_used). Both use valid/ready; an item moves when both are high.
// The table lives in a single-port-write, registered-read memory of
// TABLE_ENTRIES rows. Each route scans the used rows in order, one read
// issued per cycle with each compare in the cycle after its read, and
// stops at the first destination match.
// One route is in flight at a time; req.ready is high only while the scan
// engine is idle.
// The rsp output is a register: a new route is accepted while an earlier
// result still waits, and the next result is held back until rsp.ready.
// Reset empties the table (used count to zero) at once; no clearing pass,
// row contents stay unknown until written and are never read before that.
module distance_vector_route_merge_core
    import dvrm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    dvrm_req_if.sink        req,
    dvrm_rsp_if.source      rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    issue_reg;
    logic                rd_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    route_entry_t        rd_data_reg;

    logic [ADDR_W-1:0]   dest_reg;
    logic [ADDR_W-1:0]   hop_reg;
    logic [COST_W-1:0]   cost_reg;

    action_t             res_act_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic [COST_W-1:0]   res_cost_reg;
    logic [CNT_W-1:0]    res_used_reg;

    logic                rsp_valid_reg;
    logic [ACTION_W-1:0] rsp_act_reg;
    logic [INDEX_W-1:0]  rsp_idx_reg;
    logic [COST_W-1:0]   rsp_cost_reg;
    logic [USED_W-1:0]   rsp_used_reg;

    route_entry_t        table_mem [TABLE_ENTRIES];

    logic                rd_en;
    logic                hit;
    logic                scan_end;
    logic [COST_W:0]     cost_sum;
    logic [COST_W-1:0]   new_cost;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    route_entry_t        wr_data;
    action_t             act_next;
    logic [IDX_W-1:0]    idx_next;
    logic [COST_W-1:0]   cost_next;
    logic [CNT_W-1:0]    used_next;
    logic [IDX_W+INDEX_W-1:0] idx_wide;
    logic [CNT_W+USED_W-1:0]  used_wide;

    assign cost_sum = {1'b0, cost_reg} + {{COST_W{1'b0}}, 1'b1};
    assign new_cost = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

    assign hit      = rd_valid_reg && (rd_data_reg.dest == dest_reg);
    assign scan_end = !rd_valid_reg && (issue_reg >= used_reg);
    assign rd_en    = (state_reg == ST_SCAN) && (issue_reg < used_reg) && !hit;

    always_comb
    begin
        act_next  = ACT_FULL;
        idx_next  = '0;
        cost_next = '0;
        used_next = used_reg;
        wr_en     = 1'b0;
        wr_addr   = cmp_idx_reg;
        wr_data   = '{dest: dest_reg, hop: hop_reg, cost: new_cost};
        if (hit)
        begin
            idx_next = cmp_idx_reg;
            if (cost_sum < {1'b0, rd_data_reg.cost})
            begin
                act_next  = ACT_BETTER;
                cost_next = new_cost;
                wr_en     = 1'b1;
            end
            else if (rd_data_reg.hop == hop_reg)
            begin
                act_next  = ACT_REFRESH;
                cost_next = new_cost;
                wr_en     = 1'b1;
            end
            else
            begin
                act_next  = ACT_IGNORE;
                cost_next = rd_data_reg.cost;
            end
        end
        else if (used_reg < TABLE_FULL)
        begin
            // no match: append at the first free row
            act_next  = ACT_INSERT;
            idx_next  = used_reg[IDX_W-1:0];
            cost_next = new_cost;
            used_next = used_reg + {{(CNT_W-1){1'b0}}, 1'b1};
            wr_addr   = used_reg[IDX_W-1:0];
            wr_en     = scan_end;
        end
        if (state_reg != ST_SCAN)
        begin
            wr_en = 1'b0;
        end
    end

    assign idx_wide  = {{INDEX_W{1'b0}}, res_idx_reg};
    assign used_wide = {{USED_W{1'b0}}, res_used_reg};

    // table memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[issue_reg[IDX_W-1:0]];
            cmp_idx_reg <= issue_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            // in ST_PUSH the push below decides valid
            if (rsp_valid_reg && rsp.ready && (state_reg != ST_PUSH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        dest_reg  <= req.dest_addr;
                        hop_reg   <= req.next_hop_addr;
                        cost_reg  <= req.route_cost;
                        issue_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_reg <= issue_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                    if (hit || scan_end)
                    begin
                        res_act_reg  <= act_next;
                        res_idx_reg  <= idx_next;
                        res_cost_reg <= cost_next;
                        res_used_reg <= used_next;
                        used_reg     <= used_next;
                        state_reg    <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_act_reg   <= res_act_reg;
                        rsp_idx_reg   <= idx_wide[INDEX_W-1:0];
                        rsp_cost_reg  <= res_cost_reg;
                        rsp_used_reg  <= used_wide[USED_W-1:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.merge_action = rsp_act_reg;
    assign rsp.entry_index  = rsp_idx_reg;
    assign rsp.stored_cost  = rsp_cost_reg;
    assign rsp.entries_used = rsp_used_reg;

endmodule

// File: src/dvrm_checker.sv
module dvrm_checker
    import dvrm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [ACTION_W-1:0] merge_action,
    input logic [INDEX_W-1:0]  entry_index,
    input logic [COST_W-1:0]   stored_cost,
    input logic [USED_W-1:0]   entries_used
);

    // a stalled result item must hold
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(merge_action)
            && $stable(entry_index) && $stable(stored_cost) && $stable(entries_used))
        else $error("rsp changed while stalled");

    // one route in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while busy");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> merge_action <= ACT_FULL)
        else $error("bad merge_action");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && merge_action == ACT_FULL |-> entry_index == '0 && stored_cost == '0)
        else $error("dropped route reports slot or cost");

    // a written cost is at least one hop
    a_written_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (merge_action == ACT_BETTER || merge_action == ACT_REFRESH
            || merge_action == ACT_INSERT) |-> stored_cost != '0)
        else $error("written cost is zero");

endmodule

bind distance_vector_route_merge_core dvrm_checker u_dvrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .merge_action (rsp.merge_action),
    .entry_index  (rsp.entry_index),
    .stored_cost  (rsp.stored_cost),
    .entries_used (rsp.entries_used)
);

// File: test/route_merge_checker.sv
module route_merge_checker
    import dvrm_pkg::*;
#(
    parameter int TABLE_ROWS = 128
) (
    input  logic clk,
    input  logic rst_n,
    dvrm_req_if  req,
    dvrm_rsp_if  rsp,
    output int   failures,
    output int   merges_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        action_t             action;
        logic [INDEX_W-1:0]  index;
        logic [COST_W-1:0]   cost;
        logic [USED_W-1:0]   used;
    } merge_result_t;

    // Shadow of the routing table; rows at or above rows_used are never read.
    logic [ADDR_W-1:0] dest_rows [TABLE_ROWS];
    logic [ADDR_W-1:0] hop_rows  [TABLE_ROWS];
    logic [COST_W-1:0] cost_rows [TABLE_ROWS];
    int                rows_used = 0;

    merge_result_t     merges_due [$];
    int                mismatches = 0;

    function automatic merge_result_t merge_route(input logic [ADDR_W-1:0] dest,
                                                  input logic [ADDR_W-1:0] hop,
                                                  input logic [COST_W-1:0] adv_cost);
        merge_result_t     res;
        logic [COST_W:0]   sum;
        logic [COST_W-1:0] new_cost;
        int                row;
        // compare on the 9-bit sum, store the saturated value
        sum      = {1'b0, adv_cost} + {{COST_W{1'b0}}, 1'b1};
        new_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        row      = 0;
        while (row < rows_used && dest_rows[row] != dest)
            row++;
        if (row < rows_used)
        begin
            res.index = INDEX_W'(row);
            if (sum < {1'b0, cost_rows[row]})
                res.action = ACT_BETTER;
            else if (hop_rows[row] == hop)
                res.action = ACT_REFRESH;
            else
                res.action = ACT_IGNORE;
            if (res.action != ACT_IGNORE)
            begin
                hop_rows[row]  = hop;
                cost_rows[row] = new_cost;
            end
            res.cost = cost_rows[row];
        end
        else if (rows_used >= TABLE_ROWS)
        begin
            res.action = ACT_FULL;
            res.index  = '0;
            res.cost   = '0;
        end
        else
        begin
            dest_rows[row] = dest;
            hop_rows[row]  = hop;
            cost_rows[row] = new_cost;
            rows_used++;
            res.action = ACT_INSERT;
            res.index  = INDEX_W'(row);
            res.cost   = new_cost;
        end
        res.used = USED_W'(rows_used);
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        merge_result_t due;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                merges_due.push_back(merge_route(req.dest_addr, req.next_hop_addr,
                                                 req.route_cost));
            if (rsp.valid && rsp.ready)
            begin
                if (merges_due.size() == 0)
                begin
                    $error("merge result with no route outstanding: action %0d index %0d",
                           rsp.merge_action, rsp.entry_index);
                    mismatches++;
                end
                else
                begin
                    due = merges_due.pop_front();
                    compare_field("merge_action", 32'(due.action), 32'(rsp.merge_action));
                    compare_field("entry_index", 32'(due.index), 32'(rsp.entry_index));
                    compare_field("stored_cost", 32'(due.cost), 32'(rsp.stored_cost));
                    compare_field("entries_used", 32'(due.used), 32'(rsp.entries_used));
                end
            end
        end
        failures       <= mismatches;
        merges_pending <= merges_due.size();
    end

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dvrm_pkg::*;

    localparam int TABLE_ROWS     = 128;
    localparam int POOL_SIZE      = 150;   // more than the table holds, so it fills
    localparam int RANDOM_ROUTES  = 1140;
    localparam int TAIL_FROM      = 1000;  // no idling on either side from here on
    localparam int LONG_HOLD_AT   = 300;
    localparam int LONG_HOLD      = 600;
    localparam int PAUSE_AT       = 700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 140;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   merges_pending;
    int   routes_accepted = 0;

    logic [ADDR_W-1:0] dest_pool [POOL_SIZE];
    logic [ADDR_W-1:0] last_hop  [POOL_SIZE];
    logic [ADDR_W-1:0] hop_pool  [4];

    always #5 clk = ~clk;

    dvrm_req_if req_ch ();
    dvrm_rsp_if rsp_ch ();

    distance_vector_route_merge_core #(
        .TABLE_ENTRIES (TABLE_ROWS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    route_merge_checker #(
        .TABLE_ROWS (TABLE_ROWS)
    ) table_mirror (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .failures       (failures),
        .merges_pending (merges_pending)
    );

    // valid stays high after an accept unless the next item is preceded by a gap
    task automatic offer_route(input logic [ADDR_W-1:0] dest, input logic [ADDR_W-1:0] hop,
                               input logic [COST_W-1:0] cost, input int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.dest_addr     <= dest;
        req_ch.next_hop_addr <= hop;
        req_ch.route_cost    <= cost;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        routes_accepted <= routes_accepted + 1;
    endtask

    // mostly known destinations so that matches, refreshes and a full table happen
    function automatic void pick_route(output logic [ADDR_W-1:0] dest,
                                       output logic [ADDR_W-1:0] hop,
                                       output logic [COST_W-1:0] cost);
        int slot;
        int pick;
        slot = $urandom_range(0, POOL_SIZE - 1);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            hop = last_hop[slot];
        else if (pick < 7)
            hop = hop_pool[$urandom_range(0, 3)];
        else
            hop = $urandom;
        if ($urandom_range(0, 19) < 3)
            dest = $urandom;
        else
        begin
            dest = dest_pool[slot];
            last_hop[slot] = hop;
        end
        case ($urandom_range(0, 9))
            0:       cost = '0;
            1:       cost = COST_MAX;
            2:       cost = COST_MAX - COST_W'(1);
            3, 4:    cost = COST_W'($urandom_range(0, 7));
            default: cost = COST_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : route_source
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [COST_W-1:0] cost;
        int                n;
        int                k;
        bit                dup;
        bit                sender_idles;
        int                gap;
        req_ch.valid         <= 1'b0;
        req_ch.dest_addr     <= '0;
        req_ch.next_hop_addr <= '0;
        req_ch.route_cost    <= '0;
        rst_n                <= 1'b0;
        for (n = 0; n < POOL_SIZE; n++)
        begin
            do
            begin
                dest_pool[n] = $urandom;
                dup = 1'b0;
                for (k = 0; k < n; k++)
                    if (dest_pool[k] == dest_pool[n])
                        dup = 1'b1;
            end
            while (dup);
            last_hop[n] = $urandom;
        end
        for (n = 0; n < 4; n++)
            hop_pool[n] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: address extremes, every action but full, cost saturation
        offer_route('0, '0, '0, 0);                                   // insert, row 0
        offer_route('0, '0, '0, 0);                                   // equal cost, same hop
        offer_route('0, '1, 8'd5, 0);                                 // worse, other hop
        offer_route('1, '1, COST_MAX, 0);                             // insert, saturates
        offer_route('1, '0, COST_MAX - COST_W'(1), 0);                // sum equals stored
        offer_route('1, '0, 8'd253, 0);                               // better by one
        offer_route('1, '0, COST_MAX, 0);                             // same hop, worse
        offer_route('1, 32'hA5A5_A5A5, '0, 0);                        // better, new hop
        offer_route(32'h5A5A_5A5A, 32'h1234_5678, 8'd128, 3);
        offer_route(32'h5A5A_5A5A, 32'h8765_4321, 8'd200, 0);         // ignored at row 2
        offer_route('0, 32'hFFFF_0000, '0, 0);                        // ignored at row 0
        offer_route(32'h8000_0001, 32'h0000_FFFF, 8'd127, 5);
        offer_route(32'h8000_0001, 32'h0000_FFFF, 8'd1, 0);           // better at row 3

        sender_idles = 1'b0;
        for (n = 0; n < RANDOM_ROUTES; n++)
        begin
            if (n % 50 == 0)
                sender_idles = $urandom_range(0, 2) != 0;
            if (n == PAUSE_AT)
            begin
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (merges_pending != 0);
            end
            gap = 0;
            if (sender_idles && n < TAIL_FROM && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 11);
            pick_route(dest, hop, cost);
            offer_route(dest, hop, cost, gap);
        end
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (merges_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : result_sink
        int stretch_left;
        bit stalls_on;
        bit long_hold_done;
        stretch_left   = 0;
        stalls_on      = 1'b0;
        long_hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stretch_left == 0)
            begin
                stalls_on    = $urandom_range(0, 3) != 0;
                stretch_left = $urandom_range(40, 300);
            end
            stretch_left--;
            if (!long_hold_done && routes_accepted >= LONG_HOLD_AT)
            begin
                // long back-pressure: the result register and the scan engine fill up
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stalls_on && routes_accepted < TAIL_FROM && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
src/dvrm_pkg.sv
src/dvrm_req_if.sv
src/dvrm_rsp_if.sv
src/distance_vector_route_merge_core.sv
src/dvrm_checker.sv
test/route_merge_checker.sv
test/tb_top.sv
